### hw/rtl/uart_control_line_decoder_defines.svh
// Assertion macros for the UART control line decoder.
`ifndef UART_CONTROL_LINE_DECODER_DEFINES_SVH
`define UART_CONTROL_LINE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define UCLD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ucld assertion failed");
// Check that a condition is never true outside reset.
`define UCLD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ucld forbidden condition seen");
`else
`define UCLD_ASSERT(lbl, clk, rst, prop)
`define UCLD_NEVER(lbl, clk, rst, cond)
`endif
`endif

### hw/rtl/ucld_pkg.sv
// Constants and codes of the UART control line decoder.
`timescale 1ns / 1ps
package ucld_pkg;

   // result action codes
   localparam logic [2:0] ACT_SET_POT    = 3'd0;
   localparam logic [2:0] ACT_SET_TOGGLE = 3'd1;
   localparam logic [2:0] ACT_PRESSED    = 3'd2;
   localparam logic [2:0] ACT_NO_EVENT   = 3'd3;
   localparam logic [2:0] ACT_REJECTED   = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_UNKNOWN     = 3'd1;
   localparam logic [2:0] ERR_FIELD_COUNT = 3'd2;
   localparam logic [2:0] ERR_INDEX       = 3'd3;
   localparam logic [2:0] ERR_VALUE       = 3'd4;

   // characters
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_J       = 8'h6A;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_NUL     = 8'd0;

   // number accumulator: magnitudes saturate at NUM_CAP
   localparam int MAG_W = 21;
   localparam int MUL_W = MAG_W + 4;
   localparam logic [MAG_W-1:0] NUM_CAP   = 21'h100000;
   localparam logic [MAG_W-1:0] POT_LIMIT = 21'h00FFFF;

   // number parse phases
   typedef logic [1:0] phase_type;
   localparam phase_type PH_LEAD   = 2'd0;
   localparam phase_type PH_DIGITS = 2'd1;
   localparam phase_type PH_DONE   = 2'd2;

   // token count saturates at four: anything above three is just "too many"
   typedef logic [2:0] count_type;
   localparam count_type CNT_MAX = 3'd4;
   localparam count_type CNT_ONE = 3'd1;
   localparam count_type CNT_TWO = 3'd2;
   localparam count_type CNT_FIELDS = 3'd3;

endpackage

### hw/rtl/uart_control_line_decoder.sv
// UART control line decoder: line store, line scanner and result register.
`timescale 1ns / 1ps
// Usage
//  - req channel: one received character per request on req_rx_byte. Any byte
//    but newline (10) is written to the line store in the cycle it is taken.
//  - A newline closes the line. The block then walks the line store once,
//    one byte per cycle through its single read port, splitting at commas
//    and feeding the index and value tokens through one shared
//    multiply-by-ten accumulator. The walk reads at most len bytes (len =
//    stored line length, at most LINE_BYTES - 2) and stops early at a NUL.
//  - req_stall is high while a line is being walked and while its result
//    waits for the output register to free up.
//  - rsp channel: at most one response per line (none for a line without
//    tokens). The response sits in an output register; when rsp_stall holds
//    it, further plain bytes are still taken, and only the next newline's
//    result waits.
//  - Reset (synchronous, active high) clears the write position, the button
//    memory, the sequencer and the response valid. Line store contents are
//    not cleared; only written bytes are ever read.
`include "uart_control_line_decoder_defines.svh"

module uart_control_line_decoder #(
   parameter int LINE_BYTES   = 64,
   parameter int POT_COUNT    = 8,
   parameter int BUTTON_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [2:0]  rsp_item_index,
   output logic [15:0] rsp_pot_reading,
   output logic        rsp_button_level,
   output logic [2:0]  rsp_error_code
);

   localparam int AW    = $clog2(LINE_BYTES);
   localparam int BTN_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
   localparam int MAG_W = ucld_pkg::MAG_W;
   localparam int MUL_W = ucld_pkg::MUL_W;
   localparam logic [AW-1:0] WRAP_POS = AW'(LINE_BYTES - 1);
   localparam logic [AW-1:0] FULL_LEN = AW'(LINE_BYTES - 2);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   // line store and write side
   logic [7:0]    line_mem [LINE_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] wr_addr;
   logic          wr_en;

   // scan state
   logic [AW-1:0]             pos_ff, pos_in;
   logic [AW-1:0]             len_ff, len_in;
   logic                      in_tok_ff, in_tok_in;
   ucld_pkg::count_type       count_ff, count_in;
   logic [7:0]                kind_ff, kind_in;
   ucld_pkg::phase_type       phase_ff, phase_in;
   logic [MAG_W-1:0]          acc_ff, acc_in;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          idx_mag_ff, idx_mag_in;
   logic                      idx_neg_ff, idx_neg_in;

   // button memory
   logic                      button_ff [BUTTON_COUNT];

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  action_ff, action_in;
   logic [2:0]  index_ff, index_in;
   logic [15:0] pot_ff, pot_in;
   logic        level_ff, level_in;
   logic [2:0]  err_ff, err_in;

   logic req_take;
   logic newline_take;
   logic out_free;
   logic load_rsp;
   logic btn_update;
   logic btn_level;
   logic [BTN_W-1:0] btn_idx;

   // per-byte decode signals
   logic [7:0]          scan_byte;
   logic                is_ws, is_dig, is_sign, tok_start;
   ucld_pkg::phase_type base_phase;
   logic [MAG_W-1:0]    base_acc;
   logic                base_neg;
   logic [MUL_W-1:0]    acc_mul;
   ucld_pkg::count_type count_inc;
   ucld_pkg::count_type count_fin;
   logic                val_bad_pot, val_bad_btn, idx_neg_bad;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign newline_take = req_take && (req_rx_byte == ucld_pkg::CH_NEWLINE);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // Write position: wrap to zero before the last slot, so an overlong line overwrites its head.
   assign wr_en   = req_take && (req_rx_byte != ucld_pkg::CH_NEWLINE);
   assign wr_addr = (wp_ff >= WRAP_POS) ? '0 : wp_ff;

   // Read the byte after the one being decoded; start at zero on a newline.
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : AW'(pos_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= req_rx_byte;
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   // Character classes of the byte under decode.
   assign scan_byte = rd_data_ff;
   assign is_ws     = (scan_byte == ucld_pkg::CH_SPACE) ||
                      ((scan_byte >= ucld_pkg::CH_TAB) && (scan_byte <= ucld_pkg::CH_CR));
   assign is_dig    = (scan_byte >= ucld_pkg::CH_ZERO) && (scan_byte <= ucld_pkg::CH_NINE);
   assign is_sign   = (scan_byte == ucld_pkg::CH_PLUS) || (scan_byte == ucld_pkg::CH_MINUS);
   assign tok_start = !in_tok_ff && (scan_byte != ucld_pkg::CH_COMMA);

   // A new token restarts the number parser before this byte is applied.
   assign base_phase = tok_start ? ucld_pkg::PH_LEAD : phase_ff;
   assign base_acc   = tok_start ? '0 : acc_ff;
   assign base_neg   = tok_start ? 1'b0 : neg_ff;

   // Shared accumulator: acc * 10 + digit.
   assign acc_mul = {1'b0, base_acc, 3'b000} + {3'b000, base_acc, 1'b0} +
                    MUL_W'(scan_byte[3:0]);

   assign count_inc = (count_ff == ucld_pkg::CNT_MAX) ? ucld_pkg::CNT_MAX :
                      ucld_pkg::count_type'(count_ff + 1'b1);
   // Token still open at the end of the line counts as closed.
   assign count_fin = in_tok_ff ? count_inc : count_ff;

   // Range checks for the final decision.
   assign idx_neg_bad = idx_neg_ff && (idx_mag_ff != '0);
   assign val_bad_pot = (neg_ff && (acc_ff != '0)) || (acc_ff > ucld_pkg::POT_LIMIT);
   assign val_bad_btn = (neg_ff && (acc_ff != '0)) || (acc_ff > MAG_W'(1));
   assign btn_idx     = idx_mag_ff[BTN_W-1:0];
   assign btn_level   = (acc_ff == '0);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      in_tok_in    = in_tok_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      idx_mag_in   = idx_mag_ff;
      idx_neg_in   = idx_neg_ff;
      load_rsp     = 1'b0;
      btn_update   = 1'b0;
      action_in    = action_ff;
      index_in     = index_ff;
      pot_in       = pot_ff;
      level_in     = level_ff;
      err_in       = err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               wp_in = AW'(wr_addr + 1'b1);
            end
            if (newline_take) begin
               // Snapshot line length, drop the write position, clear the scan.
               len_in    = (wp_ff < WRAP_POS) ? wp_ff : FULL_LEN;
               wp_in     = '0;
               pos_in    = '0;
               in_tok_in = 1'b0;
               count_in  = '0;
               phase_in  = ucld_pkg::PH_LEAD;
               acc_in    = '0;
               neg_in    = 1'b0;
               state_in  = (len_in == '0) ? ST_FINISH : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (scan_byte == ucld_pkg::CH_NUL) begin
               // NUL ends the text early.
               state_in = ST_FINISH;
            end else begin
               if (scan_byte == ucld_pkg::CH_COMMA) begin
                  if (in_tok_ff) begin
                     count_in = count_inc;
                     if (count_ff == ucld_pkg::CNT_ONE) begin
                        idx_mag_in = acc_ff;
                        idx_neg_in = neg_ff;
                     end
                  end
                  in_tok_in = 1'b0;
               end else begin
                  in_tok_in = 1'b1;
                  if (count_ff == '0) begin
                     kind_in = scan_byte;
                  end
                  // Parse index and value tokens; others do not matter.
                  if ((count_ff == ucld_pkg::CNT_ONE) || (count_ff == ucld_pkg::CNT_TWO)) begin
                     phase_in = base_phase;
                     acc_in   = base_acc;
                     neg_in   = base_neg;
                     case (base_phase)
                        ucld_pkg::PH_LEAD: begin
                           if (is_dig) begin
                              acc_in   = (acc_mul > MUL_W'(ucld_pkg::NUM_CAP)) ?
                                         ucld_pkg::NUM_CAP : acc_mul[MAG_W-1:0];
                              phase_in = ucld_pkg::PH_DIGITS;
                           end else if (is_sign) begin
                              neg_in   = (scan_byte == ucld_pkg::CH_MINUS);
                              phase_in = ucld_pkg::PH_DIGITS;
                           end else if (!is_ws) begin
                              phase_in = ucld_pkg::PH_DONE;
                           end
                        end
                        ucld_pkg::PH_DIGITS: begin
                           if (is_dig) begin
                              acc_in = (acc_mul > MUL_W'(ucld_pkg::NUM_CAP)) ?
                                       ucld_pkg::NUM_CAP : acc_mul[MAG_W-1:0];
                           end else begin
                              phase_in = ucld_pkg::PH_DONE;
                           end
                        end
                        default: begin
                           phase_in = ucld_pkg::PH_DONE;
                        end
                     endcase
                  end
               end
               if (pos_ff == AW'(len_ff - 1'b1)) begin
                  state_in = ST_FINISH;
               end else begin
                  pos_in = AW'(pos_ff + 1'b1);
               end
            end
         end

         ST_FINISH: begin
            if (count_fin == '0) begin
               // No tokens: no response.
               state_in = ST_IDLE;
            end else if (out_free) begin
               load_rsp  = 1'b1;
               state_in  = ST_IDLE;
               action_in = ucld_pkg::ACT_REJECTED;
               index_in  = '0;
               pot_in    = '0;
               level_in  = 1'b0;
               err_in    = ucld_pkg::ERR_NONE;
               if ((kind_ff != ucld_pkg::CH_J) && (kind_ff != ucld_pkg::CH_B)) begin
                  err_in = ucld_pkg::ERR_UNKNOWN;
               end else if (count_fin != ucld_pkg::CNT_FIELDS) begin
                  err_in = ucld_pkg::ERR_FIELD_COUNT;
               end else if (idx_neg_bad) begin
                  err_in = ucld_pkg::ERR_INDEX;
               end else if (kind_ff == ucld_pkg::CH_J) begin
                  if (idx_mag_ff >= MAG_W'(POT_COUNT)) begin
                     err_in = ucld_pkg::ERR_INDEX;
                  end else if (val_bad_pot) begin
                     err_in = ucld_pkg::ERR_VALUE;
                  end else begin
                     action_in = ucld_pkg::ACT_SET_POT;
                     index_in  = idx_mag_ff[2:0];
                     pot_in    = acc_ff[15:0];
                  end
               end else begin
                  if (idx_mag_ff >= MAG_W'(BUTTON_COUNT)) begin
                     err_in = ucld_pkg::ERR_INDEX;
                  end else if (val_bad_btn) begin
                     err_in = ucld_pkg::ERR_VALUE;
                  end else begin
                     btn_update = 1'b1;
                     index_in   = idx_mag_ff[2:0];
                     level_in   = btn_level;
                     if (idx_mag_ff == '0) begin
                        action_in = ucld_pkg::ACT_SET_TOGGLE;
                     end else if (btn_level && !button_ff[btn_idx]) begin
                        action_in = ucld_pkg::ACT_PRESSED;
                     end else begin
                        action_in = ucld_pkg::ACT_NO_EVENT;
                     end
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until the receiver takes it.
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            button_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (btn_update) begin
            button_ff[btn_idx] <= btn_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      len_ff     <= len_in;
      in_tok_ff  <= in_tok_in;
      count_ff   <= count_in;
      kind_ff    <= kind_in;
      phase_ff   <= phase_in;
      acc_ff     <= acc_in;
      neg_ff     <= neg_in;
      idx_mag_ff <= idx_mag_in;
      idx_neg_ff <= idx_neg_in;
      action_ff  <= action_in;
      index_ff   <= index_in;
      pot_ff     <= pot_in;
      level_ff   <= level_in;
      err_ff     <= err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_item_index   = index_ff;
   assign rsp_pot_reading  = pot_ff;
   assign rsp_button_level = level_ff;
   assign rsp_error_code   = err_ff;

   // A scan never runs past the captured line length.
   `UCLD_ASSERT(a_scan_in_line, clock, reset, (state_ff == ST_SCAN) |-> (pos_ff < len_ff))
   // A newline always starts line processing.
   `UCLD_ASSERT(a_newline_busy, clock, reset, newline_take |=> (state_ff != ST_IDLE))
   // Only rejections carry an error code.
   `UCLD_NEVER(a_err_only_reject, clock, reset,
      rsp_valid_ff && (action_ff != ucld_pkg::ACT_REJECTED) && (err_ff != ucld_pkg::ERR_NONE))

endmodule
